// ===== rtl/osbf_pkg.sv =====
// Shared constants and types of the overlap-save block filter.
package osbf_pkg;

  localparam int BLOCK_LEN_DEF     = 32;
  localparam int TRANSFORM_LEN_DEF = 64;

  localparam int CMD_W   = 2;
  localparam int DATA_W  = 16;
  localparam int TIDX_W  = 6;
  localparam int TCFG_W  = 6;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_EMIT,
    S_SHIFT
  } osbf_state_t;

endpackage

// ===== rtl/overlap_save_block_fir.sv =====
// Overlap-save block FIR filter with one complex MAC over history and tap memories.
//
// Complex samples are pushed into the upper half of a TRANSFORM_LEN history; the push
// that completes a block of TRANSFORM_LEN-BLOCK_LEN samples starts BLOCK_LEN outputs,
// each a complex dot product of the taps in use with the history, rounded half up
// and saturated to Q1.15. One MAC step a cycle reads one tap and one history word
// from their memories, and each output can stall in S_EMIT on out_tready. After the
// last output of a block the upper half of the history is copied down. No input
// is taken during that work. Tap writes and history clears give no output.
// Commands travel in in_tuser.
module overlap_save_block_fir
  import osbf_pkg::*;
#(
  parameter int BLOCK_LEN     = BLOCK_LEN_DEF,
  parameter int TRANSFORM_LEN = TRANSFORM_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TCFG_W-1:0] cfg_wdata,     // tap_count
  input  logic              in_tvalid,
  output logic              in_tready,
  // sample_re[15:0], sample_im[31:16], tap_index[37:32], tap_re[53:38], tap_im[69:54]
  input  logic [71:0]       in_tdata,
  input  logic [CMD_W-1:0]  in_tuser,      // command
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,     // out_re[15:0], out_im[31:16]
  output logic              out_tlast      // last
);

  localparam int TAP_DEPTH = TRANSFORM_LEN / 2 + 1;
  localparam int FILL_LEN  = TRANSFORM_LEN - BLOCK_LEN;
  localparam int HW        = $clog2(TRANSFORM_LEN);
  localparam int TW        = $clog2(TAP_DEPTH);
  localparam int TCW       = $clog2(TAP_DEPTH + 1);
  localparam int FCW       = $clog2(FILL_LEN + 1);
  localparam int NW        = $clog2(BLOCK_LEN);
  localparam int SW        = $clog2(BLOCK_LEN + 1);
  localparam int PW        = 2 * DATA_W;
  localparam int ACC_W     = PW + 2 + TCW;

  function automatic logic [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] q;
    s = {acc[ACC_W-1], acc} + (ACC_W+1)'(16384);
    q = s >>> 15;
    if (q > (ACC_W+1)'(32767))        round_sat = 16'h7fff;
    else if (q < -(ACC_W+1)'(32768))  round_sat = 16'h8000;
    else                              round_sat = q[DATA_W-1:0];
  endfunction

  // input fields
  logic signed [DATA_W-1:0] in_sample_re, in_sample_im, in_tap_re, in_tap_im;
  logic [TIDX_W-1:0]        in_tap_index;
  assign in_sample_re = in_tdata[15:0];
  assign in_sample_im = in_tdata[31:16];
  assign in_tap_index = in_tdata[37:32];
  assign in_tap_re    = in_tdata[53:38];
  assign in_tap_im    = in_tdata[69:54];

  osbf_state_t state_r, state_nxt;

  logic [TCFG_W-1:0] tap_count_r;
  logic [FCW-1:0]    fill_r;
  logic [NW-1:0]     n_r;
  logic [TCW-1:0]    k_r;
  logic [HW-1:0]     base_r, ptr_r;
  logic [SW-1:0]     sh_r;
  logic              v1_r, v2_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic              out_tvalid_r, out_tlast_r;
  logic [DATA_W-1:0] out_re_r, out_im_r;

  logic [TCW-1:0] taps_eff;
  logic [HW-1:0]  base_init, base_inc;
  assign taps_eff  = (int'(tap_count_r) > TAP_DEPTH) ? TCW'(TAP_DEPTH) : TCW'(tap_count_r);
  assign base_init = (int'(taps_eff) >= TRANSFORM_LEN) ? '0 : HW'(taps_eff);
  assign base_inc  = (int'(base_r) == TRANSFORM_LEN - 1) ? '0 : base_r + HW'(1);

  // memories
  logic [PW-1:0] hist_mem [TRANSFORM_LEN];
  logic [PW-1:0] tap_mem  [TAP_DEPTH];
  logic [TRANSFORM_LEN-1:0] hist_vld_r;
  logic [TAP_DEPTH-1:0]     tap_vld_r;
  logic [PW-1:0] hist_rd_r, tap_rd_r, fwd_d_r;
  logic          hvld_rd_r, tvld_rd_r, fwd_r;
  logic [PW-1:0] hist_seen, tap_seen;

  logic          in_acc, issue, emit_ok, last_push, hist_clr;
  logic          hist_we, tap_we;
  logic [HW-1:0] hist_wa, hist_ra;
  logic [TW-1:0] tap_wa;
  logic [PW-1:0] hist_wd;

  assign in_acc    = in_tvalid && in_tready;
  assign last_push = in_acc && in_tuser == CMD_PUSH && int'(fill_r) == FILL_LEN - 1;
  assign hist_seen = fwd_r ? fwd_d_r : (hvld_rd_r ? hist_rd_r : '0);
  assign tap_seen  = tvld_rd_r ? tap_rd_r : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (last_push) state_nxt = S_MAC;
      S_MAC:   if (taps_eff == '0 || k_r == taps_eff - TCW'(1)) state_nxt = S_DRAIN;
      S_DRAIN: if (!v1_r && !v2_r) state_nxt = S_EMIT;
      S_EMIT:  if (emit_ok) state_nxt = (int'(n_r) == BLOCK_LEN - 1) ? S_SHIFT : S_MAC;
      S_SHIFT: if (int'(sh_r) == BLOCK_LEN) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    emit_ok   = 1'b0;
    hist_we   = 1'b0;
    hist_wa   = '0;
    hist_wd   = '0;
    hist_ra   = ptr_r;
    hist_clr  = 1'b0;
    tap_we    = 1'b0;
    tap_wa    = TW'(in_tap_index);
    case (state_r)
      S_IDLE: begin
        in_tready = rst_n;
        if (in_acc) begin
          case (in_tuser)
            CMD_PUSH: begin
              hist_we = 1'b1;
              hist_wa = HW'(BLOCK_LEN + int'(fill_r));
              hist_wd = {in_sample_im, in_sample_re};
            end
            CMD_TAP:   tap_we   = int'(in_tap_index) < TAP_DEPTH;
            CMD_CLEAR: hist_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_MAC:   issue   = taps_eff != '0;
      S_EMIT:  emit_ok = !out_tvalid_r || out_tready;
      S_SHIFT: begin
        hist_ra = (int'(sh_r) + BLOCK_LEN >= TRANSFORM_LEN) ?
                  HW'(int'(sh_r) + BLOCK_LEN - TRANSFORM_LEN) : HW'(int'(sh_r) + BLOCK_LEN);
        hist_we = sh_r != '0;
        hist_wa = HW'(sh_r - SW'(1));
        hist_wd = hist_seen;
      end
      default: ;
    endcase
  end

  // history memory and its valid bits
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_rd_r <= hist_mem[hist_ra];
    hvld_rd_r <= hist_vld_r[hist_ra];
    fwd_d_r   <= hist_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
      fwd_r      <= 1'b0;
    end else begin
      fwd_r <= hist_we && hist_wa == hist_ra;
      if (hist_clr)     hist_vld_r <= '0;
      else if (hist_we) hist_vld_r[hist_wa] <= 1'b1;
    end
  end

  // tap memory and its valid bits
  always_ff @(posedge clk) begin
    if (tap_we) tap_mem[tap_wa] <= {in_tap_im, in_tap_re};
    tap_rd_r  <= tap_mem[TW'(k_r)];
    tvld_rd_r <= tap_vld_r[TW'(k_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)      tap_vld_r <= '0;
    else if (tap_we) tap_vld_r[tap_wa] <= 1'b1;
  end

  // product stage
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  always_ff @(posedge clk) begin
    p_rr_r <= $signed(tap_seen[15:0])  * $signed(hist_seen[15:0]);
    p_ii_r <= $signed(tap_seen[31:16]) * $signed(hist_seen[31:16]);
    p_ri_r <= $signed(tap_seen[15:0])  * $signed(hist_seen[31:16]);
    p_ir_r <= $signed(tap_seen[31:16]) * $signed(hist_seen[15:0]);
  end

  // control and accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tap_count_r  <= TCFG_W'(1);
      fill_r       <= '0;
      n_r          <= '0;
      k_r          <= '0;
      base_r       <= '0;
      ptr_r        <= '0;
      sh_r         <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      acc_re_r     <= '0;
      acc_im_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      if (cfg_we) tap_count_r <= cfg_wdata;
      if (in_acc && in_tuser == CMD_CLEAR) fill_r <= '0;
      if (in_acc && in_tuser == CMD_PUSH) fill_r <= last_push ? '0 : fill_r + FCW'(1);
      if (last_push) begin
        n_r      <= '0;
        k_r      <= '0;
        base_r   <= base_init;
        ptr_r    <= base_init;
        sh_r     <= '0;
        acc_re_r <= '0;
        acc_im_r <= '0;
      end
      if (issue) begin
        k_r   <= k_r + TCW'(1);
        ptr_r <= (ptr_r == '0) ? HW'(TRANSFORM_LEN - 1) : ptr_r - HW'(1);
      end
      if (v2_r) begin
        acc_re_r <= acc_re_r + ACC_W'(p_rr_r) - ACC_W'(p_ii_r);
        acc_im_r <= acc_im_r + ACC_W'(p_ri_r) + ACC_W'(p_ir_r);
      end
      if (out_tvalid_r && out_tready && !emit_ok) out_tvalid_r <= 1'b0;
      if (emit_ok) begin
        out_tvalid_r <= 1'b1;
        acc_re_r     <= '0;
        acc_im_r     <= '0;
        n_r          <= n_r + NW'(1);
        k_r          <= '0;
        base_r       <= base_inc;
        ptr_r        <= base_inc;
      end
      if (state_r == S_SHIFT) sh_r <= sh_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      out_re_r    <= round_sat(acc_re_r);
      out_im_r    <= round_sat(acc_im_r);
      out_tlast_r <= int'(n_r) == BLOCK_LEN - 1;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_im_r, out_re_r};
  assign out_tlast  = out_tlast_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) < FILL_LEN) else $error("fill count out of range");
  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r)) else $error("product stage without read stage");
  a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> !v1_r && !v2_r) else $error("emit with MAC in flight");
  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ok |=> out_tvalid_r) else $error("emitted result not presented");

endmodule

// ===== bench/overlap_save_block_fir_tb.sv =====
// Self-checking bench for the overlap-save block FIR: random commands, stalls and tap counts.
`timescale 1ns / 100ps

module overlap_save_block_fir_tb;
  import osbf_pkg::*;

  localparam int BLK       = 32;
  localparam int XFORM     = 64;
  localparam int TAP_DEPTH = XFORM / 2 + 1;
  localparam int WDOG_MAX  = 20000;
  localparam int SETTLE    = 100;
  localparam int HOLD_LEN  = 3000;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
  } filt_out_t;

  class filter_scoreboard;
    logic signed [15:0] hist_re[XFORM];
    logic signed [15:0] hist_im[XFORM];
    logic signed [15:0] coef_re[TAP_DEPTH];
    logic signed [15:0] coef_im[TAP_DEPTH];
    int unsigned fill;
    int unsigned ntaps;
    int unsigned errors;
    int unsigned outputs_seen;
    filt_out_t   expected_outputs[$];

    function new();
      for (int i = 0; i < XFORM; i++) begin
        hist_re[i] = 0;
        hist_im[i] = 0;
      end
      for (int i = 0; i < TAP_DEPTH; i++) begin
        coef_re[i] = 0;
        coef_im[i] = 0;
      end
      fill = 0;
      ntaps = 1;
      errors = 0;
      outputs_seen = 0;
    endfunction

    function logic signed [15:0] round_sat(longint acc);
      longint q;
      q = (acc + 16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [71:0] d);
      int unsigned taps, xi;
      longint acc_re, acc_im;
      filt_out_t o;
      if (cmd == CMD_TAP) begin
        if (d[37:32] < TAP_DEPTH) begin
          coef_re[d[37:32]] = d[53:38];
          coef_im[d[37:32]] = d[69:54];
        end
      end else if (cmd == CMD_CLEAR) begin
        for (int i = 0; i < XFORM; i++) begin
          hist_re[i] = 0;
          hist_im[i] = 0;
        end
        fill = 0;
      end else if (cmd == CMD_PUSH) begin
        hist_re[BLK + fill] = d[15:0];
        hist_im[BLK + fill] = d[31:16];
        fill++;
        if (fill == XFORM - BLK) begin
          fill = 0;
          taps = (ntaps > TAP_DEPTH) ? TAP_DEPTH : ntaps;
          for (int n = 0; n < BLK; n++) begin
            acc_re = 0;
            acc_im = 0;
            for (int k = 0; k < taps; k++) begin
              xi = (n + taps - k) % XFORM;
              acc_re += longint'(coef_re[k]) * hist_re[xi] - longint'(coef_im[k]) * hist_im[xi];
              acc_im += longint'(coef_re[k]) * hist_im[xi] + longint'(coef_im[k]) * hist_re[xi];
            end
            o.re = round_sat(acc_re);
            o.im = round_sat(acc_im);
            o.last = (n == BLK - 1);
            expected_outputs.push_back(o);
          end
          for (int i = 0; i < BLK; i++) begin
            hist_re[i] = hist_re[i + BLK];
            hist_im[i] = hist_im[i + BLK];
          end
        end
      end
    endfunction

    function void check_result(logic [31:0] d, logic last);
      filt_out_t e;
      outputs_seen++;
      if (expected_outputs.size() == 0) begin
        $error("unexpected output re=%0d im=%0d", $signed(d[15:0]), $signed(d[31:16]));
        errors++;
        return;
      end
      e = expected_outputs.pop_front();
      if (d[15:0] !== e.re) begin
        $error("out_re expected %0d actual %0d", e.re, $signed(d[15:0]));
        errors++;
      end
      if (d[31:16] !== e.im) begin
        $error("out_im expected %0d actual %0d", e.im, $signed(d[31:16]));
        errors++;
      end
      if (last !== e.last) begin
        $error("last expected %0b actual %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic [TCFG_W-1:0] cfg_wdata = '0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [71:0]       in_tdata = '0;
  logic [CMD_W-1:0]  in_tuser = CMD_PUSH;
  logic              out_tvalid;
  logic              out_tready = 0;
  logic [31:0]       out_tdata;
  logic              out_tlast;

  filter_scoreboard sb = new();
  int unsigned tx_idle = 28;
  int unsigned rx_idle = 87;
  bit          hold_go = 0;
  int unsigned hold_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned requests_sent = 0;

  overlap_save_block_fir DUT (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_cnt = HOLD_LEN;
      hold_go = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, logic signed [15:0] s_re, logic signed [15:0] s_im,
                      logic [5:0] idx, logic signed [15:0] t_re, logic signed [15:0] t_im);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, t_im, t_re, idx, s_im, s_re};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(cmd, {2'b00, t_im, t_re, idx, s_im, s_re});
    requests_sent++;
  endtask

  task automatic push(logic signed [15:0] re, logic signed [15:0] im);
    send(CMD_PUSH, re, im, 6'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // wait for the block to drain, then write tap_count
  task automatic set_tap_count(logic [TCFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (sb.expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.ntaps = value;
  endtask

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_requests(int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 86) begin
        push(rand_value(), rand_value());
      end else if (pick < 95) begin
        send(CMD_TAP, 16'($urandom), 16'($urandom), 6'($urandom_range(40)),
             rand_value(), rand_value());
      end else if (pick < 98) begin
        send(CMD_CLEAR, 16'($urandom), 16'($urandom), 6'($urandom), 16'($urandom),
             16'($urandom));
      end else begin
        send(CMD_UNKNOWN, 16'($urandom), 16'($urandom), 6'($urandom), 16'($urandom),
             16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // taps at both ends of the store, out-of-range indexes, unknown command
    send(CMD_TAP, 0, 0, 6'd0, 16'sh8000, 16'sh8000);
    send(CMD_TAP, 0, 0, 6'd32, 16'sh7fff, 16'sh7fff);
    send(CMD_TAP, 0, 0, 6'd33, 16'sh7fff, 16'sh0001);
    send(CMD_TAP, 0, 0, 6'd63, 16'sh1234, 16'sh8000);
    send(CMD_UNKNOWN, 16'sh7fff, 16'sh7fff, 6'd0, 16'sh7fff, 16'sh7fff);
    push(16'sh7fff, 16'sh7fff);
    send(CMD_CLEAR, 0, 0, 6'd0, 0, 0);
    push(16'sh8000, 16'sh8000);
    push(16'sh8000, 16'sh7fff);
    push(16'sh7fff, 16'sh8000);
    push(16'sh0000, 16'sh0000);
    push(16'sh0001, 16'shffff);
    push(16'sh7fff, 16'sh7fff);
    random_requests(105);

    set_tap_count(6'd33);
    tx_idle = 87;
    rx_idle = 28;
    random_requests(110);

    set_tap_count(6'd0);
    tx_idle = 0;
    rx_idle = 0;
    random_requests(60);

    set_tap_count(6'd63);
    hold_go = 1;
    random_requests(70);

    set_tap_count(6'($urandom_range(2, 32)));
    random_requests(100);

    in_tvalid <= 1'b0;
    while (sb.expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d requests and checked %0d filter outputs", requests_sent, sb.outputs_seen);
    $display("Tap counts 1, 33, 0, 63 and one random; sender and receiver stalls varied");
    if (sb.errors == 0 && sb.expected_outputs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/osbf_pkg.sv
rtl/overlap_save_block_fir.sv
bench/overlap_save_block_fir_tb.sv
